### design/ipcr_pkg.sv
// Shared types and constants for the rendezvous message-passing scheduler.
// Holds the per-process record layout kept in the process table memory.
// No dependencies.
package ipcr_pkg;

  localparam int NPROC = 8;
  localparam int PW    = $clog2(NPROC);

  localparam logic [3:0] NIL      = 4'hF;
  localparam logic [3:0] PEER_ANY = 4'd8;
  localparam logic [3:0] PEER_HW  = 4'd9;

  localparam logic [1:0] F_SEND = 2'b01;
  localparam logic [1:0] F_RECV = 2'b10;

  localparam logic [2:0] CMD_SEND    = 3'd0;
  localparam logic [2:0] CMD_RECV    = 3'd1;
  localparam logic [2:0] CMD_SENDREC = 3'd2;
  localparam logic [2:0] CMD_INTR    = 3'd3;
  localparam logic [2:0] CMD_SWITCH  = 3'd4;
  localparam logic [2:0] CMD_ROTATE  = 3'd5;

  typedef struct packed {
    logic [1:0]    flags;
    logic [PW-1:0] st;
    logic [3:0]    rs;
    logic [31:0]   addr;
    logic          ip;
    logic [3:0]    ch;
    logic [3:0]    cn;
    logic [3:0]    rn;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  function automatic logic is_proc(input logic [3:0] x);
    return x < 4'(NPROC);
  endfunction

  // value of an entry never written since reset
  function automatic rec_t rst_rec(input logic [PW-1:0] i);
    rec_t r;
    r    = '0;
    r.ch = NIL;
    r.cn = NIL;
    r.rn = (int'(i) + 1 < NPROC) ? 4'(int'(i) + 1) : NIL;
    return r;
  endfunction

endpackage

### design/ipcr_ram.sv
// Simple dual-port RAM with registered read data and write-to-read forwarding.
// Generic; no package dependency.
module ipcr_ram #(
  parameter int W = 8,
  parameter int D = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= (we && waddr == raddr) ? wdata : mem[raddr];
    end
  end

endmodule

### design/ipc_rendezvous_scheduler.sv
// Rendezvous message-passing scheduler over a fixed process table.
// Uses ipcr_pkg and ipcr_ram (process table memory).
//
// Requests arrive on s_t*: cmd, peer and msg_addr, issued on behalf of the
// running process. Each request yields one or two results on m_t*, the final
// one marked by m_tlast: status, an optional copy request (from/to address,
// sender, interrupt flag) and the process running afterwards.
// cfg_* writes the idle process number; it is taken at any time but is only
// meant to change while no request is in flight.
// One request is handled at a time; s_tready is high only while idle.
// All per-process records sit in a single memory with registered reads, so
// the time a request takes is set by the memory accesses of its walk, which
// is longest for a send with long sender chains and caller queues; the
// handover of each result adds to it.
// Results are held until m_tready; nothing further is accepted meanwhile.
// Reset (rst, synchronous) makes every process ready in queue order 0..NPROC-1
// with process 0 running; a valid bit per entry stands in for table reset, so
// no clearing pass is needed.
module ipc_rendezvous_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // cmd[2:0], peer[6:3], msg_addr[38:7]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // status[0], copy_valid[1], from_addr[33:2],
                                 // to_addr[65:34], sender[69:66],
                                 // is_interrupt[70], current_process[73:71]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data
);
  import ipcr_pkg::*;

  typedef enum logic [27:0] {
    S_IDLE   = 28'd1 << 0,
    S_SD_D   = 28'd1 << 1,
    S_SD_CHK = 28'd1 << 2,
    S_SD_CW  = 28'd1 << 3,
    S_SD_DL  = 28'd1 << 4,
    S_SD_Q   = 28'd1 << 5,
    S_SD_O   = 28'd1 << 6,
    S_AS     = 28'd1 << 7,
    S_RV_C   = 28'd1 << 8,
    S_RV_W   = 28'd1 << 9,
    S_RV_P   = 28'd1 << 10,
    S_RV_UH  = 28'd1 << 11,
    S_RV_UP  = 28'd1 << 12,
    S_RV_I   = 28'd1 << 13,
    S_IN_T   = 28'd1 << 14,
    S_SW0    = 28'd1 << 15,
    S_SW1    = 28'd1 << 16,
    S_SW2    = 28'd1 << 17,
    S_MR0    = 28'd1 << 18,
    S_MR1    = 28'd1 << 19,
    S_MR2    = 28'd1 << 20,
    S_MU0    = 28'd1 << 21,
    S_MU1    = 28'd1 << 22,
    S_MU2    = 28'd1 << 23,
    S_MU3    = 28'd1 << 24,
    S_MU4    = 28'd1 << 25,
    S_OUT0   = 28'd1 << 26,
    S_OUT1   = 28'd1 << 27
  } state_t;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [3:0]       peer;
    logic [31:0]      addr;
    logic [PW-1:0]    caller;
    logic             status;
    logic [1:0]       ndlv;
    logic [1:0][31:0] dfrom;
    logic [1:0][31:0] dto;
    logic [1:0][3:0]  dwho;
    logic [1:0]       dint;
    logic [PW-1:0]    idx;
    logic [PW:0]      n;
    logic [3:0]       p;
    logic [3:0]       prev;
    logic [3:0]       chead;
    logic [3:0]       tmp;
    logic             mr;
    logic [PW-1:0]    mp;
    logic             rot;
    state_t           ret;
    logic [3:0]       head;
    logic [3:0]       tail;
    logic [PW-1:0]    run;
  } ctx_t;

  state_t        st, st_n;
  ctx_t          c, nx;
  logic [2:0]    idle;
  logic [NPROC-1:0] vld;
  logic          qv;
  logic [PW-1:0] raddr_q;
  logic [REC_W-1:0] q;
  rec_t          cur, w;
  logic          m_we, m_re;
  logic [PW-1:0] m_ra;
  logic          k;
  logic          cv;

  function automatic ctx_t add_dlv(input ctx_t x, input logic [31:0] f,
                                   input logic [31:0] t, input logic [3:0] who,
                                   input logic intr);
    ctx_t r;
    r = x;
    r.dfrom[x.ndlv[0]] = f;
    r.dto[x.ndlv[0]]   = t;
    r.dwho[x.ndlv[0]]  = who;
    r.dint[x.ndlv[0]]  = intr;
    r.ndlv = x.ndlv + 2'd1;
    return r;
  endfunction

  function automatic logic [PW-1:0] idle_pid(input logic [2:0] i);
    return (int'(i) < NPROC) ? PW'(i) : '0;
  endfunction

  ipcr_ram #(.W(REC_W), .D(NPROC)) u_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (raddr_q),
    .wdata (w),
    .re    (m_re),
    .raddr (m_ra),
    .rdata (q)
  );

  assign cur = qv ? rec_t'(q) : rst_rec(raddr_q);

  always_comb begin
    nx   = c;
    st_n = st;
    m_re = 1'b0;
    m_ra = c.caller;
    m_we = 1'b0;
    w    = cur;
    unique case (st) inside
      S_IDLE: begin
        if (s_tvalid) begin
          nx.cmd    = s_tdata[2:0];
          nx.peer   = s_tdata[6:3];
          nx.addr   = s_tdata[38:7];
          nx.caller = c.run;
          nx.status = 1'b0;
          nx.ndlv   = '0;
          nx.ret    = S_OUT0;
          case (s_tdata[2:0]) inside
            CMD_SEND, CMD_SENDREC: begin
              if (is_proc(s_tdata[6:3])) begin
                m_re = 1'b1; m_ra = s_tdata[PW+2:3]; st_n = S_SD_D;
              end else if (s_tdata[2:0] == CMD_SENDREC) begin
                m_re = 1'b1; m_ra = c.run; st_n = S_RV_C;
              end else begin
                st_n = S_OUT0;
              end
            end
            CMD_RECV: begin
              m_re = 1'b1; m_ra = c.run; st_n = S_RV_C;
            end
            CMD_INTR: begin
              if (is_proc(s_tdata[6:3])) begin
                m_re = 1'b1; m_ra = s_tdata[PW+2:3]; st_n = S_IN_T;
              end else begin
                st_n = S_OUT0;
              end
            end
            CMD_SWITCH, CMD_ROTATE: begin
              nx.rot = (s_tdata[2:0] == CMD_ROTATE);
              st_n   = S_SW0;
            end
            default: st_n = S_OUT0;
          endcase
        end
      end
      // send: sender chain check
      S_SD_D: begin
        if (cur.flags[0]) begin
          nx.idx = cur.st; nx.n = '0; st_n = S_SD_CHK;
        end else begin
          m_re = 1'b1; m_ra = c.peer[PW-1:0]; st_n = S_SD_DL;
        end
      end
      S_SD_CHK: begin
        if (c.idx == c.caller) begin
          nx.status = 1'b1; st_n = S_OUT0;
        end else begin
          m_re = 1'b1; m_ra = c.idx; st_n = S_SD_CW;
        end
      end
      S_SD_CW: begin
        if (!cur.flags[0]) begin
          m_re = 1'b1; m_ra = c.peer[PW-1:0]; st_n = S_SD_DL;
        end else if (c.n == (PW+1)'(NPROC)) begin
          nx.status = 1'b1; st_n = S_OUT0;
        end else begin
          nx.idx = cur.st; nx.n = c.n + 1'b1; st_n = S_SD_CHK;
        end
      end
      S_SD_DL: begin
        if (cur.flags == F_RECV && (cur.rs == PEER_ANY || cur.rs == 4'(c.caller))) begin
          nx = add_dlv(c, c.addr, cur.addr, 4'(c.caller), 1'b0);
          w.flags = '0;
          m_we = 1'b1;
          nx.mp = c.peer[PW-1:0]; nx.ret = S_AS; st_n = S_MR0;
        end else if (!is_proc(cur.ch)) begin
          w.ch = 4'(c.caller);
          m_we = 1'b1;
          m_re = 1'b1; m_ra = c.caller; st_n = S_SD_O;
        end else begin
          nx.n = '0;
          m_re = 1'b1; m_ra = cur.ch[PW-1:0]; st_n = S_SD_Q;
        end
      end
      S_SD_Q: begin
        if (c.n != (PW+1)'(NPROC) && is_proc(cur.cn)) begin
          nx.n = c.n + 1'b1;
          m_re = 1'b1; m_ra = cur.cn[PW-1:0];
        end else begin
          w.cn = 4'(c.caller);
          m_we = 1'b1;
          m_re = 1'b1; m_ra = c.caller; st_n = S_SD_O;
        end
      end
      S_SD_O: begin
        w.cn    = NIL;
        w.addr  = c.addr;
        w.st    = c.peer[PW-1:0];
        w.flags = cur.flags | F_SEND;
        m_we = 1'b1;
        if ((cur.flags | F_SEND) == F_SEND) begin
          nx.mp = c.caller; nx.ret = S_AS; st_n = S_MU0;
        end else begin
          st_n = S_AS;
        end
      end
      S_AS: begin
        nx.ret = S_OUT0;
        if (c.cmd == CMD_SENDREC) begin
          m_re = 1'b1; m_ra = c.caller; st_n = S_RV_C;
        end else begin
          st_n = S_OUT0;
        end
      end
      // receive
      S_RV_C, S_RV_I: begin
        if (st == S_RV_C && !cur.flags[0]) begin
          nx.p = cur.ch; nx.chead = cur.ch; nx.prev = NIL; nx.n = '0;
          st_n = S_RV_W;
        end else if (st == S_RV_I && cur.ip &&
                     (c.peer == PEER_HW || c.peer == PEER_ANY)) begin
          nx = add_dlv(c, '0, c.addr, PEER_HW, 1'b1);
          w.ip = 1'b0;
          m_we = 1'b1;
          st_n = S_OUT0;
        end else begin
          w.rs    = c.peer;
          w.addr  = c.addr;
          w.flags = cur.flags | F_RECV;
          m_we = 1'b1;
          nx.ret = S_OUT0;
          if ((cur.flags | F_RECV) == F_RECV) begin
            nx.mp = c.caller; st_n = S_MU0;
          end else begin
            st_n = S_OUT0;
          end
        end
      end
      S_RV_W: begin
        m_re = 1'b1;
        if (c.n != (PW+1)'(NPROC) && is_proc(c.p)) begin
          m_ra = c.p[PW-1:0]; st_n = S_RV_P;
        end else begin
          m_ra = c.caller; st_n = S_RV_I;
        end
      end
      S_RV_P: begin
        if (c.peer == PEER_ANY || c.peer == c.p) begin
          nx = add_dlv(c, cur.addr, c.addr, c.p, 1'b0);
          nx.tmp = cur.cn;
          nx.mr  = ((cur.flags & ~F_SEND) == 2'b00);
          nx.mp  = c.p[PW-1:0];
          nx.ret = S_OUT0;
          w.flags = cur.flags & ~F_SEND;
          m_we = 1'b1;
          if (c.p == c.chead) begin
            m_re = 1'b1; m_ra = c.caller; st_n = S_RV_UH;
          end else if (is_proc(c.prev)) begin
            m_re = 1'b1; m_ra = c.prev[PW-1:0]; st_n = S_RV_UP;
          end else if ((cur.flags & ~F_SEND) == 2'b00) begin
            st_n = S_MR0;
          end else begin
            st_n = S_OUT0;
          end
        end else begin
          nx.prev = c.p; nx.p = cur.cn; nx.n = c.n + 1'b1;
          st_n = S_RV_W;
        end
      end
      S_RV_UH, S_RV_UP: begin
        if (st == S_RV_UH) begin
          w.ch = c.tmp;
        end else begin
          w.cn = c.tmp;
        end
        m_we = 1'b1;
        st_n = c.mr ? S_MR0 : S_OUT0;
      end
      // interrupt
      S_IN_T: begin
        m_we = 1'b1;
        if (cur.flags != F_RECV || !(cur.rs == PEER_ANY || cur.rs == PEER_HW)) begin
          w.ip = 1'b1;
          st_n = S_OUT0;
        end else begin
          nx = add_dlv(c, '0, cur.addr, PEER_HW, 1'b1);
          w.flags = '0;
          w.ip = 1'b0;
          nx.mp = c.peer[PW-1:0]; nx.ret = S_OUT0; st_n = S_MR0;
        end
      end
      // task switch
      S_SW0: begin
        if (!is_proc(c.head)) begin
          nx.run = idle_pid(idle); st_n = c.ret;
        end else if (c.rot && is_proc(c.tail)) begin
          m_re = 1'b1; m_ra = c.tail[PW-1:0]; st_n = S_SW1;
        end else begin
          nx.run = c.head[PW-1:0]; st_n = c.ret;
        end
      end
      S_SW1: begin
        w.rn = c.head;
        m_we = 1'b1;
        m_re = 1'b1; m_ra = c.head[PW-1:0]; st_n = S_SW2;
      end
      S_SW2: begin
        w.rn = NIL;
        m_we = 1'b1;
        nx.tail = c.head;
        nx.head = cur.rn;
        nx.run  = is_proc(cur.rn) ? cur.rn[PW-1:0] : idle_pid(idle);
        st_n = c.ret;
      end
      // ready queue append
      S_MR0: begin
        m_re = 1'b1;
        if (is_proc(c.head) && is_proc(c.tail)) begin
          m_ra = c.tail[PW-1:0]; st_n = S_MR1;
        end else begin
          nx.head = 4'(c.mp); m_ra = c.mp; st_n = S_MR2;
        end
      end
      S_MR1: begin
        w.rn = 4'(c.mp);
        m_we = 1'b1;
        m_re = 1'b1; m_ra = c.mp; st_n = S_MR2;
      end
      S_MR2: begin
        w.rn = NIL;
        m_we = 1'b1;
        nx.tail = 4'(c.mp);
        st_n = c.ret;
      end
      // ready queue removal
      S_MU0: begin
        if (!is_proc(c.head)) begin
          st_n = c.ret;
        end else if (c.head == 4'(c.mp)) begin
          m_re = 1'b1; m_ra = c.mp; st_n = S_MU1;
        end else begin
          nx.idx = c.head[PW-1:0]; nx.n = '0;
          m_re = 1'b1; m_ra = c.head[PW-1:0]; st_n = S_MU2;
        end
      end
      S_MU1: begin
        nx.head = cur.rn;
        if (c.mp == c.run) begin
          nx.rot = 1'b0; st_n = S_SW0;
        end else begin
          st_n = c.ret;
        end
      end
      S_MU2: begin
        if (cur.rn == 4'(c.mp)) begin
          m_re = 1'b1; m_ra = c.mp; st_n = S_MU3;
        end else if (!is_proc(cur.rn) || c.n == (PW+1)'(NPROC - 1)) begin
          st_n = c.ret;
        end else begin
          nx.idx = cur.rn[PW-1:0]; nx.n = c.n + 1'b1;
          m_re = 1'b1; m_ra = cur.rn[PW-1:0];
        end
      end
      S_MU3: begin
        nx.tmp = cur.rn;
        m_re = 1'b1; m_ra = c.idx; st_n = S_MU4;
      end
      S_MU4: begin
        w.rn = c.tmp;
        m_we = 1'b1;
        if (c.tail == 4'(c.mp)) begin
          nx.tail = 4'(c.idx);
        end
        st_n = c.ret;
      end
      S_OUT0: begin
        if (m_tready) begin
          st_n = (c.ndlv == 2'd2) ? S_OUT1 : S_IDLE;
        end
      end
      S_OUT1: begin
        if (m_tready) begin
          st_n = S_IDLE;
        end
      end
      default: st_n = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= S_IDLE;
      idle   <= '0;
      vld    <= '0;
      c.head <= '0;
      c.tail <= 4'(NPROC - 1);
      c.run  <= '0;
    end else begin
      st <= st_n;
      c  <= nx;
      if (cfg_valid) begin
        idle <= cfg_data;
      end
      if (m_we) begin
        vld[raddr_q] <= 1'b1;
      end
    end
    if (m_re) begin
      raddr_q <= m_ra;
      qv      <= (m_we && raddr_q == m_ra) ? 1'b1 : vld[m_ra];
    end
  end

  assign s_tready  = (st == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = (st == S_OUT0) || (st == S_OUT1);
  assign k         = (st == S_OUT1);
  assign cv        = k || (c.ndlv != 2'd0);
  assign m_tlast   = k || (c.ndlv != 2'd2);

  assign m_tdata = {6'd0,
                    3'(c.run),
                    cv & c.dint[k],
                    cv ? c.dwho[k] : 4'd0,
                    cv ? c.dto[k] : 32'd0,
                    cv ? c.dfrom[k] : 32'd0,
                    cv,
                    c.status};

endmodule

### design/ipcr_checker.sv
// Port-level checks for the rendezvous scheduler, bound to the top level.
// Uses ipcr_pkg.
module ipcr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic        m_tlast
);
  import ipcr_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while busy");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("request taken with a result pending");

  a_nocopy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[1] |-> m_tlast)
    else $error("result without copy is not the last");

  a_intr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[70] |-> m_tdata[69:66] == PEER_HW && m_tdata[33:2] == 32'd0)
    else $error("bad interrupt delivery");

endmodule

bind ipc_rendezvous_scheduler ipcr_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
